### hw/rtl/sab_pkg.sv
// Shared constants and types for the skyline atlas block allocator.
`default_nettype none

package sab_pkg;

  // Atlas geometry and page count.
  localparam int ATLAS_WIDTH  = 128;
  localparam int ATLAS_HEIGHT = 128;
  localparam int MAX_PAGES    = 64;

  // Derived widths.
  localparam int COL_W  = $clog2(ATLAS_WIDTH);
  localparam int SPAN_W = $clog2(ATLAS_WIDTH + 1);
  localparam int HGT_W  = $clog2(ATLAS_HEIGHT + 1);
  localparam int PAGE_W = $clog2(MAX_PAGES);
  localparam int CNT_W  = $clog2(MAX_PAGES + 1);
  localparam int ADDR_W = PAGE_W + COL_W;
  localparam int DEPTH  = MAX_PAGES * ATLAS_WIDTH;

  // Fixed field widths of the ports.
  localparam int IN_W       = 8;
  localparam int STATUS_W   = 2;
  localparam int PAGE_IDX_W = 6;
  localparam int POS_W      = 7;
  localparam int LIMIT_W    = 7;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;

  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = LIMIT_W'(64);

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED    = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_LIMIT     = 2'd2
  } status_e;

endpackage

`default_nettype wire

### hw/rtl/skyline_atlas_block_allocator.sv
// Top level of the skyline atlas block allocator: scan, place and skyline memory.
`default_nettype none

// Channel  | Dir | Signals                               | Contents (low bit first)
// ---------+-----+---------------------------------------+-----------------------------------
// request  | in  | s_axis_tvalid/tready/tdata[15:0]      | content_width[7:0], content_height[15:8]
// result   | out | m_axis_tvalid/tready/tdata[23:0]/tuser | page_index, place_x, place_y; tuser=status
// config   | in  | cfg_we_i, cfg_wdata_i[6:0]            | page_limit, written when cfg_we_i is high
//
// Scan: the skyline memory is read one column per cycle, page by page over the open
// pages; a fit then raises the block's columns, or a newly opened page is cleared and
// filled with the block in its corner; oversized requests go straight to a result.
// Reset: after rst_ni rises a clearing pass zeroes page 0; requests wait.
// Stalls: a finished result sits in the output register; the next request is taken
// while it waits, and only a second finished result holds until the first is taken.

module skyline_atlas_block_allocator (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // content_width [7:0], content_height [15:8]
  input  wire  [sab_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // page_index [5:0], place_x [12:6], place_y [19:13], zero [23:20]
  output logic [sab_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // status [1:0]
  output logic [sab_pkg::STATUS_W-1:0]        m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  input  wire                                 cfg_we_i,
  input  wire  [sab_pkg::LIMIT_W-1:0]         cfg_wdata_i
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_WRITE = 6'b001000,
    S_FILL  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration and page bookkeeping.
  logic [sab_pkg::LIMIT_W-1:0] page_limit_q;
  logic [sab_pkg::CNT_W-1:0]   pages_open_q, pages_open_d;

  // Request being worked on.
  logic [sab_pkg::SPAN_W-1:0]  bw_q, bw_d;
  logic [sab_pkg::HGT_W-1:0]   bh_q, bh_d;
  logic [sab_pkg::PAGE_W-1:0]  page_q, page_d;

  // Read issue side and returning data side of the scan.
  logic [sab_pkg::COL_W-1:0]   iss_col_q, iss_col_d;
  logic                        iss_act_q, iss_act_d;
  logic                        dv_q, dv_d;
  logic [sab_pkg::COL_W-1:0]   dcol_q, dcol_d;
  logic [sab_pkg::SPAN_W-1:0]  run_q, run_d;
  logic [sab_pkg::HGT_W-1:0]   runmax_q, runmax_d;

  // Write-back sweep.
  logic [sab_pkg::COL_W-1:0]   wr_col_q, wr_col_d;
  logic [sab_pkg::COL_W-1:0]   wr_last_q, wr_last_d;
  logic [sab_pkg::HGT_W-1:0]   top_new_q, top_new_d;
  logic [sab_pkg::SPAN_W-1:0]  clr_w_q, clr_w_d;

  // Pending result and output register.
  sab_pkg::status_e            res_status_q, res_status_d;
  logic [sab_pkg::PAGE_IDX_W-1:0] res_page_q, res_page_d;
  logic [sab_pkg::POS_W-1:0]   res_x_q, res_x_d;
  logic [sab_pkg::POS_W-1:0]   res_y_q, res_y_d;

  logic                        out_valid_q;
  sab_pkg::status_e            out_status_q;
  logic [sab_pkg::PAGE_IDX_W-1:0] out_page_q;
  logic [sab_pkg::POS_W-1:0]   out_x_q, out_y_q;
  logic                        out_load;

  // Skyline memory: one height per column of every page.
  logic [sab_pkg::HGT_W-1:0]   mem [sab_pkg::DEPTH];
  logic                        mem_we, mem_re;
  logic [sab_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [sab_pkg::HGT_W-1:0]   mem_wdata, rdata_q;

  // Scan datapath.
  logic [sab_pkg::IN_W:0]      bw_ext, bh_ext;
  logic [sab_pkg::HGT_W:0]     hsum;
  logic                        col_ok;
  logic [sab_pkg::HGT_W-1:0]   cand_max;
  logic [sab_pkg::SPAN_W-1:0]  run_inc;
  logic [sab_pkg::SPAN_W-1:0]  start_ext;
  logic [sab_pkg::COL_W-1:0]   start_col;
  logic                        found;
  logic                        more_pages;

  assign bw_ext    = {1'b0, s_axis_tdata[sab_pkg::IN_W-1:0]} + (sab_pkg::IN_W+1)'(2);
  assign bh_ext    = {1'b0, s_axis_tdata[2*sab_pkg::IN_W-1:sab_pkg::IN_W]}
                     + (sab_pkg::IN_W+1)'(2);
  assign hsum      = {1'b0, rdata_q} + {1'b0, bh_q};
  assign col_ok    = (hsum <= (sab_pkg::HGT_W+1)'(sab_pkg::ATLAS_HEIGHT));
  assign cand_max  = (rdata_q > runmax_q) ? rdata_q : runmax_q;
  assign run_inc   = run_q + sab_pkg::SPAN_W'(1);
  assign start_ext = sab_pkg::SPAN_W'(dcol_q) + sab_pkg::SPAN_W'(1) - bw_q;
  assign start_col = start_ext[sab_pkg::COL_W-1:0];
  assign found     = dv_q && col_ok && (run_inc == bw_q);
  assign more_pages = (sab_pkg::CNT_W'(page_q) + sab_pkg::CNT_W'(1)) < pages_open_q;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    pages_open_d = pages_open_q;
    bw_d         = bw_q;
    bh_d         = bh_q;
    page_d       = page_q;
    iss_col_d    = iss_col_q;
    iss_act_d    = iss_act_q;
    dv_d         = 1'b0;
    dcol_d       = iss_col_q;
    run_d        = run_q;
    runmax_d     = runmax_q;
    wr_col_d     = wr_col_q;
    wr_last_d    = wr_last_q;
    top_new_d    = top_new_q;
    clr_w_d      = clr_w_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    mem_we       = 1'b0;
    mem_waddr    = {page_q, wr_col_q};
    mem_wdata    = top_new_q;
    mem_re       = 1'b0;
    mem_raddr    = {page_q, iss_col_q};
    out_load     = 1'b0;

    case (state_q)
      S_INIT: begin
        // Zero page 0 once after reset.
        mem_we    = 1'b1;
        mem_waddr = {sab_pkg::PAGE_W'(0), wr_col_q};
        mem_wdata = '0;
        wr_col_d  = wr_col_q + sab_pkg::COL_W'(1);
        if (wr_col_q == sab_pkg::COL_W'(sab_pkg::ATLAS_WIDTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (bw_ext > (sab_pkg::IN_W+1)'(sab_pkg::ATLAS_WIDTH) ||
              bh_ext > (sab_pkg::IN_W+1)'(sab_pkg::ATLAS_HEIGHT)) begin
            res_status_d = sab_pkg::ST_TOO_LARGE;
            res_page_d   = '0;
            res_x_d      = '0;
            res_y_d      = '0;
            state_d      = S_DONE;
          end else begin
            bw_d      = sab_pkg::SPAN_W'(bw_ext);
            bh_d      = sab_pkg::HGT_W'(bh_ext);
            page_d    = '0;
            iss_col_d = '0;
            iss_act_d = 1'b1;
            run_d     = '0;
            runmax_d  = '0;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one column read per cycle.
        if (iss_act_q) begin
          mem_re    = 1'b1;
          dv_d      = 1'b1;
          iss_col_d = iss_col_q + sab_pkg::COL_W'(1);
          if (iss_col_q == sab_pkg::COL_W'(sab_pkg::ATLAS_WIDTH - 1)) begin
            iss_act_d = 1'b0;
          end
        end
        // First run of bw columns that all leave room for bh wins.
        if (dv_q) begin
          if (found) begin
            iss_act_d    = 1'b0;
            wr_col_d     = start_col;
            wr_last_d    = dcol_q;
            top_new_d    = cand_max + bh_q;
            res_status_d = sab_pkg::ST_PLACED;
            res_page_d   = sab_pkg::PAGE_IDX_W'(page_q);
            res_x_d      = sab_pkg::POS_W'(start_col + sab_pkg::COL_W'(1));
            res_y_d      = sab_pkg::POS_W'(cand_max + sab_pkg::HGT_W'(1));
            state_d      = S_WRITE;
          end else if (col_ok) begin
            run_d    = run_inc;
            runmax_d = cand_max;
          end else begin
            run_d    = '0;
            runmax_d = '0;
          end

          if (!found && dcol_q == sab_pkg::COL_W'(sab_pkg::ATLAS_WIDTH - 1)) begin
            run_d    = '0;
            runmax_d = '0;
            if (more_pages) begin
              page_d    = page_q + sab_pkg::PAGE_W'(1);
              iss_col_d = '0;
              iss_act_d = 1'b1;
            end else if (pages_open_q >= page_limit_q ||
                         pages_open_q >= sab_pkg::CNT_W'(sab_pkg::MAX_PAGES)) begin
              res_status_d = sab_pkg::ST_LIMIT;
              res_page_d   = '0;
              res_x_d      = '0;
              res_y_d      = '0;
              state_d      = S_DONE;
            end else begin
              // Open a fresh page; the block lands in its corner.
              page_d       = sab_pkg::PAGE_W'(pages_open_q);
              pages_open_d = pages_open_q + sab_pkg::CNT_W'(1);
              clr_w_d      = bw_q;
              top_new_d    = bh_q;
              wr_col_d     = '0;
              res_status_d = sab_pkg::ST_PLACED;
              res_page_d   = sab_pkg::PAGE_IDX_W'(pages_open_q);
              res_x_d      = sab_pkg::POS_W'(1);
              res_y_d      = sab_pkg::POS_W'(1);
              state_d      = S_FILL;
            end
          end
        end
      end

      S_WRITE: begin
        // Raise the chosen columns to the new top.
        mem_we   = 1'b1;
        wr_col_d = wr_col_q + sab_pkg::COL_W'(1);
        if (wr_col_q == wr_last_q) begin
          state_d = S_DONE;
        end
      end

      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = (sab_pkg::SPAN_W'(wr_col_q) < clr_w_q) ? top_new_q : '0;
        wr_col_d  = wr_col_q + sab_pkg::COL_W'(1);
        if (wr_col_q == sab_pkg::COL_W'(sab_pkg::ATLAS_WIDTH - 1)) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      page_limit_q <= sab_pkg::PAGE_LIMIT_RST;
      pages_open_q <= sab_pkg::CNT_W'(1);
      iss_act_q    <= 1'b0;
      dv_q         <= 1'b0;
      wr_col_q     <= '0;
      clr_w_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pages_open_q <= pages_open_d;
      iss_act_q    <= iss_act_d;
      dv_q         <= dv_d;
      wr_col_q     <= wr_col_d;
      clr_w_q      <= clr_w_d;
      if (cfg_we_i) begin
        page_limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bw_q         <= bw_d;
    bh_q         <= bh_d;
    page_q       <= page_d;
    iss_col_q    <= iss_col_d;
    dcol_q       <= dcol_d;
    run_q        <= run_d;
    runmax_q     <= runmax_d;
    wr_last_q    <= wr_last_d;
    top_new_q    <= top_new_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_page_q   <= res_page_q;
      out_x_q      <= res_x_q;
      out_y_q      <= res_y_q;
    end
  end

  // Skyline memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {
    (sab_pkg::M_TDATA_W - sab_pkg::PAGE_IDX_W - 2*sab_pkg::POS_W)'(0),
    out_y_q, out_x_q, out_page_q
  };

  // The page count only ever grows by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pages_open_q != $past(pages_open_q)) |->
      (pages_open_q == $past(pages_open_q) + sab_pkg::CNT_W'(1)))
    else $error("page count moved by other than one");

  // Open pages stay within one and the page maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pages_open_q >= sab_pkg::CNT_W'(1)) &&
    (pages_open_q <= sab_pkg::CNT_W'(sab_pkg::MAX_PAGES)))
    else $error("open page count out of range");

  // A placed result names a page that is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sab_pkg::ST_PLACED) |->
      (sab_pkg::CNT_W'(out_page_q) < pages_open_q))
    else $error("placed result on a page that is not open");

  // The skyline is never written while the block waits for a request or to hand over a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
    else $error("skyline write outside a placement");

endmodule

`default_nettype wire

### dv/tb_skyline_atlas_block_allocator.sv
// Testbench for the skyline atlas block allocator: directed and random requests vs. a skyline model.
`default_nettype none

module tb_skyline_atlas_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest quiet stretch: a failing request that scans every page, or the long receiver
  // hold-off; the limit allows several times the longer of the two.
  localparam int QUIET_LIMIT = 50000;
  localparam int REPORT_MAX  = 10;
  localparam int DRAIN_TAIL  = 300;

  typedef struct packed {
    sab_pkg::status_e                       status;
    logic [sab_pkg::PAGE_IDX_W-1:0]         page;
    logic [sab_pkg::POS_W-1:0]              x;
    logic [sab_pkg::POS_W-1:0]              y;
  } placement_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic [sab_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [sab_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic [sab_pkg::STATUS_W-1:0]  m_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic                          cfg_we_i;
  logic [sab_pkg::LIMIT_W-1:0]   cfg_wdata_i;

  // Skyline model: one height per column per page, open page count, limit register.
  int skyline [sab_pkg::MAX_PAGES][sab_pkg::ATLAS_WIDTH];
  int pages_opened = 1;
  int page_limit_q = int'(sab_pkg::PAGE_LIMIT_RST);

  placement_t placements_due[$];

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_len  = 0;
  int rx_hold_tag  = 0;
  int rx_hold_seen = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;
  int faults       = 0;

  skyline_atlas_block_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Scan one page left to right for the first start column where the block fits
  // under the page height; raise the covered columns to the new top.
  function automatic bit fit_on_page(input int pg, input int bw, input int bh,
                                     output int px, output int py);
    int top;
    int j;
    px = 0;
    py = 0;
    for (int start = 0; start + bw <= sab_pkg::ATLAS_WIDTH; start++) begin
      top = 0;
      for (j = 0; j < bw; j++) begin
        if (skyline[pg][start + j] > top) top = skyline[pg][start + j];
        if (top + bh > sab_pkg::ATLAS_HEIGHT) break;
      end
      if (j == bw) begin
        for (int k = 0; k < bw; k++) skyline[pg][start + k] = top + bh;
        px = start;
        py = top;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Place one request: gutter on all sides, open pages first, then a fresh page.
  function automatic placement_t predict_placement(input logic [sab_pkg::IN_W-1:0] w,
                                                   input logic [sab_pkg::IN_W-1:0] h);
    placement_t r;
    int bw;
    int bh;
    int px;
    int py;
    int pg;
    bit placed;
    bw = int'(w) + 2;
    bh = int'(h) + 2;
    r = '{status: sab_pkg::ST_PLACED, page: '0, x: '0, y: '0};
    placed = 1'b0;
    if (bw > sab_pkg::ATLAS_WIDTH || bh > sab_pkg::ATLAS_HEIGHT) begin
      r.status = sab_pkg::ST_TOO_LARGE;
      return r;
    end
    for (pg = 0; pg < pages_opened && pg < sab_pkg::MAX_PAGES; pg++) begin
      if (fit_on_page(pg, bw, bh, px, py)) begin
        placed = 1'b1;
        break;
      end
    end
    if (!placed) begin
      if (pages_opened >= page_limit_q || pages_opened >= sab_pkg::MAX_PAGES) begin
        r.status = sab_pkg::ST_LIMIT;
        return r;
      end
      pg = pages_opened;
      for (int c = 0; c < sab_pkg::ATLAS_WIDTH; c++) skyline[pg][c] = 0;
      pages_opened++;
      if (!fit_on_page(pg, bw, bh, px, py)) begin
        r.status = sab_pkg::ST_LIMIT;
        return r;
      end
    end
    r.page = sab_pkg::PAGE_IDX_W'(pg);
    r.x    = sab_pkg::POS_W'(px + 1);
    r.y    = sab_pkg::POS_W'(py + 1);
    return r;
  endfunction

  // Mostly small blocks, some up to a full page, a few beyond the field's page range.
  function automatic logic [sab_pkg::IN_W-1:0] random_extent();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return sab_pkg::IN_W'($urandom_range(0, 20));
    if (pick < 90) return sab_pkg::IN_W'($urandom_range(0, 126));
    return sab_pkg::IN_W'($urandom_range(0, 255));
  endfunction

  // Offer one request, hold it until the transfer, then record the expected placement.
  task automatic send_request(input logic [sab_pkg::IN_W-1:0] w,
                              input logic [sab_pkg::IN_W-1:0] h);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {h, w};
    do @(posedge clk_i); while (!s_axis_tready);
    placements_due.push_back(predict_placement(w, h));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (placements_due.size() != 0) @(posedge clk_i);
  endtask

  // Write the page limit only once every pending result is out.
  task automatic set_page_limit(input logic [sab_pkg::LIMIT_W-1:0] value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    page_limit_q = int'(value);
  endtask

  task automatic test_directed();
    set_page_limit(sab_pkg::LIMIT_W'(1));
    send_request(8'd0, 8'd0);       // gutter-only block at the origin
    send_request(8'd255, 8'd255);   // both fields at their top
    send_request(8'd127, 8'd10);    // one column too wide
    send_request(8'd10, 8'd127);    // one row too tall
    send_request(8'd126, 8'd0);     // full page width
    send_request(8'd126, 8'd126);   // no room, single page allowed
    send_request(8'd0, 8'd126);     // full height needs a bare column
    set_page_limit(sab_pkg::LIMIT_W'(0));
    send_request(8'd0, 8'd0);
    send_request(8'd126, 8'd124);   // limit of zero opens nothing
    set_page_limit(sab_pkg::LIMIT_W'(127));
    send_request(8'd126, 8'd126);   // opens the second page, fills it
    send_request(8'd0, 8'd0);
    send_request(8'd128, 8'd3);
    send_request(8'd3, 8'd128);
    send_request(8'd1, 8'd1);
    send_request(8'd5, 8'd9);
    send_request(8'd64, 8'd2);
    send_request(8'd0, 8'd60);
    wait_drained();
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct,
                                  input logic [sab_pkg::LIMIT_W-1:0] limit_value,
                                  input int count);
    set_page_limit(limit_value);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) send_request(random_extent(), random_extent());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    run_random_phase(26, 47, sab_pkg::LIMIT_W'(3), 67);
    run_random_phase(47, 26, sab_pkg::LIMIT_W'($urandom_range(4, 6)), 67);
    run_random_phase(0, 0, sab_pkg::LIMIT_W'(6), 66);
  endtask

  // Stall the result side long enough for the input to back up, then pause the
  // sender until every pending result has drained.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_drained();
    @(posedge clk_i);
    rx_hold_len = 2000;
    rx_hold_tag++;
    repeat (6) send_request(sab_pkg::IN_W'($urandom_range(0, 6)),
                            sab_pkg::IN_W'($urandom_range(0, 6)));
    wait_drained();
    repeat (4) send_request(sab_pkg::IN_W'($urandom_range(0, 6)),
                            sab_pkg::IN_W'($urandom_range(0, 6)));
    wait_drained();
  endtask

  // Open every page with full-page blocks, then hit both page bounds.
  task automatic test_page_exhaustion();
    int guard;
    guard = 0;
    set_page_limit(sab_pkg::LIMIT_W'(sab_pkg::MAX_PAGES));
    while (pages_opened < sab_pkg::MAX_PAGES && guard < 2 * sab_pkg::MAX_PAGES) begin
      send_request(8'd126, 8'd126);
      guard++;
    end
    send_request(8'd126, 8'd126);
    set_page_limit(sab_pkg::LIMIT_W'(127));
    send_request(8'd126, 8'd126);
    send_request(8'd0, 8'd0);
    send_request(8'd255, 8'd0);
    wait_drained();
  endtask

  // Receiver: hold off during a requested stretch, else stall at random.
  always @(negedge clk_i) begin
    if (rx_hold_tag != rx_hold_seen) begin
      rx_hold_seen = rx_hold_tag;
      rx_hold_left = rx_hold_len;
    end
    if (rx_hold_left > 0) begin
      m_axis_tready = 1'b0;
      rx_hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expected placement.
  always @(posedge clk_i) begin
    placement_t want;
    placement_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{status: sab_pkg::status_e'(m_axis_tuser),
              page:   m_axis_tdata[sab_pkg::PAGE_IDX_W-1:0],
              x:      m_axis_tdata[sab_pkg::PAGE_IDX_W +: sab_pkg::POS_W],
              y:      m_axis_tdata[sab_pkg::PAGE_IDX_W + sab_pkg::POS_W +: sab_pkg::POS_W]};
      if (placements_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("unexpected result: status %0d page %0d x %0d y %0d",
                   got.status, got.page, got.x, got.y);
      end else begin
        want = placements_due.pop_front();
        if (got !== want) begin
          faults++;
          if (faults <= REPORT_MAX)
            $display("mismatch: expected status %0d page %0d x %0d y %0d, got %0d %0d %0d %0d",
                     want.status, want.page, want.x, want.y,
                     got.status, got.page, got.x, got.y);
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_traffic();
    test_backpressure();
    test_page_exhaustion();

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (faults == 0 && placements_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
